// ===== rtl/core/mi3_pkg.sv =====
// Shared types and constants for the 3x3 fixed-point matrix inverse unit.
// No dependencies; every module of the unit refers to this package by scoped names.
`timescale 1ns / 1ps

package mi3_pkg;

  // Matrix geometry.
  localparam int MAT_DIM   = 3;
  localparam int NUM_ELEMS = MAT_DIM * MAT_DIM;

  // Decoupling queue between the cofactor front end and the divider back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  // Status of the decoupling queue, seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/core/matrix3x3_inverse_unit.sv =====
// 3x3 signed fixed-point matrix inverse by the adjugate, with saturation.
// The result word strobes on done once the matrix has passed the front end, the queue and the back end.
// Throughput: one matrix per cycle while busy is low; the nine one-bit-per-stage divider pipelines set the depth.
// Reset: rst is synchronous and active high; it empties every stage and the queue.
// The receiver cannot stall, so busy only rises while reset is held or the queue is full.
`timescale 1ns / 1ps

module matrix3x3_inverse_unit #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] m_r0c0,
  input  logic signed [DATA_WIDTH-1:0] m_r0c1,
  input  logic signed [DATA_WIDTH-1:0] m_r0c2,
  input  logic signed [DATA_WIDTH-1:0] m_r1c0,
  input  logic signed [DATA_WIDTH-1:0] m_r1c1,
  input  logic signed [DATA_WIDTH-1:0] m_r1c2,
  input  logic signed [DATA_WIDTH-1:0] m_r2c0,
  input  logic signed [DATA_WIDTH-1:0] m_r2c1,
  input  logic signed [DATA_WIDTH-1:0] m_r2c2,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] inv_r0c0,
  output logic signed [DATA_WIDTH-1:0] inv_r0c1,
  output logic signed [DATA_WIDTH-1:0] inv_r0c2,
  output logic signed [DATA_WIDTH-1:0] inv_r1c0,
  output logic signed [DATA_WIDTH-1:0] inv_r1c1,
  output logic signed [DATA_WIDTH-1:0] inv_r1c2,
  output logic signed [DATA_WIDTH-1:0] inv_r2c0,
  output logic signed [DATA_WIDTH-1:0] inv_r2c1,
  output logic signed [DATA_WIDTH-1:0] inv_r2c2,
  output logic                         singular
);

  localparam int W       = DATA_WIDTH;
  localparam int CW      = 2 * W + 1;
  localparam int DETW    = 3 * W + 3;
  localparam int N       = mi3_pkg::NUM_ELEMS;
  localparam int QW      = N * CW + DETW;
  localparam int LATENCY = DATA_WIDTH + 10;

  logic                  accept;
  logic signed [W-1:0]   m_vec   [N];
  logic signed [W-1:0]   inv_vec [N];

  // Front end outputs: adjugate entries and determinant of one matrix.
  logic                  fwd_valid;
  logic signed [CW-1:0]  fwd_cof [N];
  logic signed [DETW-1:0] fwd_det;
  logic [QW-1:0]         fwd_word;

  // Queue head, unpacked for the divider back end.
  logic [QW-1:0]         head_word;
  logic signed [CW-1:0]  head_cof [N];
  logic signed [DETW-1:0] head_det;
  mi3_pkg::qstat_t       qstat;
  logic                  head_valid;

  // A matrix is taken whenever start is high and the unit is not busy.
  assign busy   = rst || qstat.full;
  assign accept = start && !busy;

  assign m_vec[0] = m_r0c0;
  assign m_vec[1] = m_r0c1;
  assign m_vec[2] = m_r0c2;
  assign m_vec[3] = m_r1c0;
  assign m_vec[4] = m_r1c1;
  assign m_vec[5] = m_r1c2;
  assign m_vec[6] = m_r2c0;
  assign m_vec[7] = m_r2c1;
  assign m_vec[8] = m_r2c2;

  mi3_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .m         (m_vec),
    .out_valid (fwd_valid),
    .cof       (fwd_cof),
    .det       (fwd_det)
  );

  // The queue word holds the nine adjugate entries followed by the determinant.
  for (genvar k = 0; k < N; k++) begin : g_pack
    assign fwd_word[k*CW +: CW] = fwd_cof[k];
    assign head_cof[k]          = head_word[k*CW +: CW];
  end
  assign fwd_word[N*CW +: DETW] = fwd_det;
  assign head_det               = head_word[N*CW +: DETW];

  // The back end takes a word every cycle, so the head is popped as soon as it exists.
  assign head_valid = !qstat.empty;

  mi3_queue #(
    .WORD_BITS (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fwd_valid),
    .wdata (fwd_word),
    .pop   (head_valid),
    .rdata (head_word),
    .qstat (qstat)
  );

  mi3_back #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (head_valid),
    .cof      (head_cof),
    .det      (head_det),
    .done     (done),
    .inv      (inv_vec),
    .singular (singular)
  );

  assign inv_r0c0 = inv_vec[0];
  assign inv_r0c1 = inv_vec[1];
  assign inv_r0c2 = inv_vec[2];
  assign inv_r1c0 = inv_vec[3];
  assign inv_r1c1 = inv_vec[4];
  assign inv_r1c2 = inv_vec[5];
  assign inv_r2c0 = inv_vec[6];
  assign inv_r2c1 = inv_vec[7];
  assign inv_r2c2 = inv_vec[8];

  // The front end never pushes a word into a full queue.
  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    fwd_valid |-> !qstat.full)
    else $error("front end pushed into a full queue");

  // Every accepted matrix produces its result word after the fixed latency.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted matrix produced no result word");

  // No result word appears without a matrix accepted the fixed latency earlier.
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result word without an accepted matrix");

endmodule

// ===== rtl/core/mi3_front.sv =====
// Front end of the 3x3 matrix inverse: captures a matrix and forms the nine
// adjugate entries and the exact determinant in a six-stage pipeline.
// Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic signed [DATA_WIDTH-1:0]     m   [mi3_pkg::NUM_ELEMS],
  output logic                             out_valid,
  output logic signed [2*DATA_WIDTH:0]     cof [mi3_pkg::NUM_ELEMS],
  output logic signed [3*DATA_WIDTH+2:0]   det
);

  localparam int W    = DATA_WIDTH;
  localparam int PW   = 2 * W;
  localparam int CW   = 2 * W + 1;
  localparam int PPW  = 2 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int N    = mi3_pkg::NUM_ELEMS;
  localparam int D    = mi3_pkg::MAT_DIM;

  logic [5:0] vld;

  logic signed [W-1:0]    a1    [N];
  logic signed [PW-1:0]   p2pos [N];
  logic signed [PW-1:0]   p2neg [N];
  logic signed [W-1:0]    a2    [D];
  logic signed [CW-1:0]   cof3  [N];
  logic signed [W-1:0]    a3    [D];
  logic signed [CW-1:0]   cof4  [N];
  logic signed [PPW-1:0]  pl4   [D];
  logic signed [PPW-1:0]  ph4   [D];
  logic signed [CW-1:0]   cof5  [N];
  logic signed [DETW-1:0] term5 [D];
  logic signed [CW-1:0]   cof6  [N];
  logic signed [DETW-1:0] det6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      a1 <= m;
    end
  end

  // Adjugate entry (r, c) is the cofactor of element (c, r).
  for (genvar k = 0; k < N; k++) begin : g_cof
    localparam int R  = k / D;
    localparam int C  = k % D;
    localparam int C1 = (C + 1) % D;
    localparam int C2 = (C + 2) % D;
    localparam int R1 = (R + 1) % D;
    localparam int R2 = (R + 2) % D;

    always_ff @(posedge clk) begin
      p2pos[k] <= a1[C1*D+R1] * a1[C2*D+R2];
      p2neg[k] <= a1[C1*D+R2] * a1[C2*D+R1];
      cof3[k]  <= CW'(p2pos[k]) - CW'(p2neg[k]);
      cof4[k]  <= cof3[k];
      cof5[k]  <= cof4[k];
      cof6[k]  <= cof5[k];
    end
  end

  // Determinant by expansion along row 0; each product is split in two halves.
  for (genvar k = 0; k < D; k++) begin : g_det
    always_ff @(posedge clk) begin
      a2[k]    <= a1[k];
      a3[k]    <= a2[k];
      pl4[k]   <= a3[k] * $signed({1'b0, cof3[k*D][W-1:0]});
      ph4[k]   <= a3[k] * $signed(cof3[k*D][CW-1:W]);
      term5[k] <= (DETW'(ph4[k]) <<< W) + DETW'(pl4[k]);
    end
  end

  always_ff @(posedge clk) begin
    det6 <= term5[0] + term5[1] + term5[2];
  end

  assign out_valid = vld[5];
  assign cof       = cof6;
  assign det       = det6;

endmodule

// ===== rtl/core/mi3_queue.sv =====
// Short word queue that decouples the cofactor front end from the divider.
// Depends on mi3_pkg for its depth and status struct.
`timescale 1ns / 1ps

module mi3_queue #(
  parameter int WORD_BITS = 1283
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WORD_BITS-1:0]  wdata,
  input  logic                  pop,
  output logic [WORD_BITS-1:0]  rdata,
  output mi3_pkg::qstat_t       qstat
);

  localparam int PB = mi3_pkg::QPTR_BITS;

  logic [WORD_BITS-1:0] mem [mi3_pkg::QUEUE_DEPTH];
  logic [PB-1:0]        wr_ptr;
  logic [PB-1:0]        rd_ptr;
  logic [PB:0]          count;
  logic                 push_ok;
  logic                 pop_ok;

  assign qstat.full  = (count == (PB+1)'(mi3_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign push_ok     = push && !qstat.full;
  assign pop_ok      = pop && !qstat.empty;
  assign rdata       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/mi3_back.sv =====
// Back end of the 3x3 matrix inverse: nine restoring dividers, one quotient bit
// per stage, followed by sign restore and saturation. Depends on mi3_pkg.
`timescale 1ns / 1ps

module mi3_back #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic signed [2*DATA_WIDTH:0]    cof [mi3_pkg::NUM_ELEMS],
  input  logic signed [3*DATA_WIDTH+2:0]  det,
  output logic                            done,
  output logic signed [DATA_WIDTH-1:0]    inv [mi3_pkg::NUM_ELEMS],
  output logic                            singular
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int CW   = 2 * W + 1;
  localparam int DETW = 3 * W + 3;
  localparam int NW   = CW + 2 * F;
  localparam int RW   = (NW > DETW + W) ? NW : DETW + W;
  localparam int N    = mi3_pkg::NUM_ELEMS;
  localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

  // Magnitude and sign stage.
  logic              v1;
  logic [DETW-1:0]   dmag1;
  logic              dneg1;
  logic              dzero1;
  logic [CW-1:0]     cmag1 [N];
  logic [N-1:0]      cneg1;

  // Divider stages; stage 0 holds the scaled numerators.
  logic [W:0]        sv;
  logic [DETW-1:0]   sdm  [W+1];
  logic [W:0]        sdz;
  logic [N-1:0]      sneg [W+1];
  logic [N-1:0]      sbig [W+1];
  logic [RW-1:0]     rem  [W+1][N];
  logic [W-1:0]      quo  [W+1][N];

  logic [W-1:0]      lim_f [N];
  logic [W-1:0]      mag_f [N];
  logic [N-1:0]      sat_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      sv <= '0;
    end else begin
      v1 <= in_valid;
      sv <= {sv[W-1:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    dneg1  <= det[DETW-1];
    dmag1  <= det[DETW-1] ? DETW'(-det) : DETW'(det);
    dzero1 <= (det == '0);
    sdm[0] <= dmag1;
    sdz[0] <= dzero1;
  end

  for (genvar k = 0; k < N; k++) begin : g_lane
    always_ff @(posedge clk) begin
      cneg1[k]   <= cof[k][CW-1];
      cmag1[k]   <= cof[k][CW-1] ? CW'(-cof[k]) : CW'(cof[k]);
      rem[0][k]  <= RW'(cmag1[k]) << (2 * F);
      sbig[0][k] <= (RW'(cmag1[k]) << (2 * F)) >= (RW'(dmag1) << W);
      sneg[0][k] <= cneg1[k] ^ dneg1;
      quo[0][k]  <= '0;
    end
  end

  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int S = W - 1 - j;
    logic [RW-1:0] dsh;
    assign dsh = RW'(sdm[j]) << S;

    always_ff @(posedge clk) begin
      sdm[j+1]  <= sdm[j];
      sdz[j+1]  <= sdz[j];
      sneg[j+1] <= sneg[j];
      sbig[j+1] <= sbig[j];
    end

    for (genvar k = 0; k < N; k++) begin : g_div
      logic ge;
      assign ge = (rem[j][k] >= dsh);
      always_ff @(posedge clk) begin
        rem[j+1][k] <= ge ? rem[j][k] - dsh : rem[j][k];
        quo[j+1][k] <= {quo[j][k][W-2:0], ge};
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_sat
    assign lim_f[k] = sneg[W][k] ? NEG_LIM : POS_LIM;
    assign sat_f[k] = sbig[W][k] || (quo[W][k] > lim_f[k]);
    assign mag_f[k] = sat_f[k] ? lim_f[k] : quo[W][k];

    always_ff @(posedge clk) begin
      if (sdz[W]) begin
        inv[k] <= '0;
      end else if (sneg[W][k]) begin
        inv[k] <= -mag_f[k];
      end else begin
        inv[k] <= mag_f[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    singular <= sdz[W] || (|sat_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[W];
    end
  end

endmodule

// ===== test/tb_matrix3x3_inverse_unit.sv =====
// Self-checking testbench for matrix3x3_inverse_unit: directed and random matrices are
// checked against an exact wide-integer adjugate inverse with saturation.
// Depends on rtl/core/mi3_pkg.sv, matrix3x3_inverse_unit.sv, mi3_front.sv, mi3_queue.sv and mi3_back.sv.
`timescale 1ns / 1ps

module tb_matrix3x3_inverse_unit;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LATENCY    = DATA_WIDTH + 10;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] ONE_VAL = 1 <<< FRAC_BITS;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  // Wide enough for the determinant (about 3*DATA_WIDTH+3 bits) and the shifted cofactor.
  typedef logic signed [159:0] wide_t;

  typedef struct {
    elem_t e[9];
  } matrix_t;

  typedef struct {
    elem_t e[9];
    logic  singular;
  } inverse_t;

  // Exact adjugate-over-determinant inverse, truncated toward zero, then saturated.
  function automatic inverse_t invert_matrix(matrix_t m);
    wide_t    a[3][3];
    wide_t    det, cof, quo;
    inverse_t res;
    int       r1, r2, c1, c2;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        a[r][c] = wide_t'(m.e[r*3+c]);
    det = a[0][0]*a[1][1]*a[2][2] + a[0][1]*a[1][2]*a[2][0] + a[0][2]*a[1][0]*a[2][1]
        - a[0][2]*a[1][1]*a[2][0] - a[0][1]*a[1][0]*a[2][2] - a[0][0]*a[1][2]*a[2][1];
    res.singular = 1'b0;
    if (det == 0) begin
      for (int k = 0; k < 9; k++) res.e[k] = '0;
      res.singular = 1'b1;
      return res;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        r1 = (r + 1) % 3;
        r2 = (r + 2) % 3;
        // Transposed cofactor: rows and columns swap roles.
        cof = a[c1][r1]*a[c2][r2] - a[c1][r2]*a[c2][r1];
        quo = (cof <<< (2*FRAC_BITS)) / det;
        if (quo > wide_t'(MAX_VAL)) begin
          res.e[r*3+c] = MAX_VAL;
          res.singular = 1'b1;
        end else if (quo < wide_t'(MIN_VAL)) begin
          res.e[r*3+c] = MIN_VAL;
          res.singular = 1'b1;
        end else begin
          res.e[r*3+c] = quo[DATA_WIDTH-1:0];
        end
      end
    end
    return res;
  endfunction

  // Holds the inverses still owed by the block, oldest first.
  class inverse_scoreboard;
    inverse_t pending[$];
    int       errors;

    function void note_matrix(matrix_t m);
      pending.push_back(invert_matrix(m));
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, nothing pending", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.e[k] !== want.e[k]) begin
          $display("%0t: inv_r%0dc%0d expected %h actual %h", $time, k / 3, k % 3,
                   want.e[k], got.e[k]);
          errors++;
        end
      if (got.singular !== want.singular) begin
        $display("%0t: singular expected %b actual %b", $time, want.singular, got.singular);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy, done, singular;
  elem_t m_in[9];
  elem_t inv_out[9];

  inverse_scoreboard sb = new();
  int accepted_words = 0;
  int idle_pct = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  matrix3x3_inverse_unit #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .m_r0c0  (m_in[0]),
    .m_r0c1  (m_in[1]),
    .m_r0c2  (m_in[2]),
    .m_r1c0  (m_in[3]),
    .m_r1c1  (m_in[4]),
    .m_r1c2  (m_in[5]),
    .m_r2c0  (m_in[6]),
    .m_r2c1  (m_in[7]),
    .m_r2c2  (m_in[8]),
    .done    (done),
    .inv_r0c0(inv_out[0]),
    .inv_r0c1(inv_out[1]),
    .inv_r0c2(inv_out[2]),
    .inv_r1c0(inv_out[3]),
    .inv_r1c1(inv_out[4]),
    .inv_r1c2(inv_out[5]),
    .inv_r2c0(inv_out[6]),
    .inv_r2c1(inv_out[7]),
    .inv_r2c2(inv_out[8]),
    .singular(singular)
  );

  // Monitor: an input word is taken at an edge with start high and busy low; a result
  // word is valid for the single cycle in which done is high.
  always @(posedge clk) begin
    matrix_t  seen;
    inverse_t got;
    cycles <= cycles + 1;
    if (!rst && start && !busy) begin
      for (int k = 0; k < 9; k++) seen.e[k] = m_in[k];
      sb.note_matrix(seen);
      accepted_words <= accepted_words + 1;
    end
    if (!rst && done) begin
      for (int k = 0; k < 9; k++) got.e[k] = inv_out[k];
      got.singular = singular;
      sb.check_inverse(got);
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("** matrix3x3_inverse_unit: FAILED **");
      $finish;
    end
  end

  // Drives one word. The task runs just after a falling edge and returns just after the
  // falling edge that follows acceptance, so start is only ever changed there.
  task automatic send_matrix(input matrix_t m);
    int taken;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    for (int k = 0; k < 9; k++) m_in[k] = m.e[k];
    taken = accepted_words;
    do @(negedge clk); while (accepted_words == taken);
  endtask

  // Holds the sender off until every pending result word has come back.
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom());
      1: return elem_t'($signed($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
      2: return elem_t'($signed($urandom_range(0, 16)) - 8);
      default: begin
        case ($urandom_range(3))
          0: return MAX_VAL;
          1: return MIN_VAL;
          2: return '0;
          default: return ONE_VAL;
        endcase
      end
    endcase
  endfunction

  // Well-conditioned matrices near a scaled identity as the largest share, plus full-range noise,
  // tiny integer entries that make the inverse saturate, extremes and singular ones.
  function automatic matrix_t rand_matrix();
    matrix_t m;
    int      shape, src, dst;
    shape = $urandom_range(99);
    for (int k = 0; k < 9; k++) begin
      if (shape < 45) m.e[k] = rand_elem(1);
      else if (shape < 65) m.e[k] = rand_elem(0);
      else if (shape < 75) m.e[k] = rand_elem(2);
      else if (shape < 82) m.e[k] = rand_elem(3);
      else m.e[k] = rand_elem(1);
    end
    if (shape < 45)
      for (int d = 0; d < 3; d++) m.e[d*4] = m.e[d*4] + (8 << FRAC_BITS);
    if (shape >= 82) begin
      // Singular: a repeated row or column, or a zero row.
      src = $urandom_range(2);
      dst = (src + 1 + $urandom_range(1)) % 3;
      for (int j = 0; j < 3; j++) begin
        case (shape % 3)
          0: m.e[dst*3+j] = m.e[src*3+j];
          1: m.e[j*3+dst] = m.e[j*3+src];
          default: m.e[dst*3+j] = '0;
        endcase
      end
    end
    return m;
  endfunction

  function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int k = 0; k < 9; k++) m.e[k] = '0;
    m.e[0] = d0;
    m.e[4] = d1;
    m.e[8] = d2;
    return m;
  endfunction

  function automatic matrix_t fill_matrix(elem_t v);
    matrix_t m;
    for (int k = 0; k < 9; k++) m.e[k] = v;
    return m;
  endfunction

  initial begin
    matrix_t m;
    int      phase_pct[4] = '{0, 62, 0, 35};

    for (int k = 0; k < 9; k++) m_in[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: identity, scaled and negative diagonals, extremes, singular cases,
    // a rotation-like matrix, and matrices whose inverse saturates.
    send_matrix(diag_matrix(ONE_VAL, ONE_VAL, ONE_VAL));
    send_matrix(diag_matrix(2 * ONE_VAL, -ONE_VAL, ONE_VAL / 2));
    send_matrix(fill_matrix('0));
    send_matrix(fill_matrix(MAX_VAL));
    send_matrix(fill_matrix(MIN_VAL));
    send_matrix(diag_matrix(MAX_VAL, MAX_VAL, MAX_VAL));
    send_matrix(diag_matrix(MIN_VAL, MIN_VAL, MIN_VAL));
    send_matrix(diag_matrix(MIN_VAL, MAX_VAL, MIN_VAL));
    send_matrix(diag_matrix(1, 1, 1));
    send_matrix(diag_matrix(-1, 1, 1));
    send_matrix(diag_matrix(1, MAX_VAL, -1));
    send_matrix(diag_matrix(ONE_VAL, '0, ONE_VAL));
    m = diag_matrix(ONE_VAL, ONE_VAL, ONE_VAL);
    m.e[1] = -ONE_VAL;
    m.e[3] = ONE_VAL;
    send_matrix(m);
    m = diag_matrix(MAX_VAL, MIN_VAL, MAX_VAL);
    m.e[2] = MIN_VAL;
    m.e[6] = MAX_VAL;
    m.e[5] = 1;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m.e[k] = elem_t'((k + 1) << FRAC_BITS);
    send_matrix(m);
    m.e[8] = 10 << FRAC_BITS;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m.e[k] = (k % 2) ? MAX_VAL : MIN_VAL;
    send_matrix(m);
    for (int k = 0; k < 9; k++) m.e[k] = elem_t'($signed(k) - 4);
    m.e[0] = 7;
    send_matrix(m);
    drain_results();

    // Random words in four phases whose sender gap chances are 0, 62, 0 and 35 percent; each phase ends with the
    // sender held off until every owed result has arrived.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      repeat (420) send_matrix(rand_matrix());
      drain_results();
    end

    start = 1'b0;
    repeat (LATENCY + 20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** matrix3x3_inverse_unit: PASSED **");
    end else begin
      $display("** matrix3x3_inverse_unit: FAILED **");
    end
    $finish;
  end

endmodule
